### src/pafl_pkg.sv
package pafl_pkg;

  // Request codes.
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BAD_IDX  = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_NUM_OBJ  = 1'b0;
  localparam logic CFG_MAXIMIZE = 1'b1;

  // Insert pointer width, covers archives up to 1024 entries.
  localparam int unsigned PTR_W = 10;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] obj_0;
    logic signed [31:0] obj_1;
    logic signed [31:0] obj_2;
    logic signed [31:0] obj_3;
    logic [31:0]        solution_tag;
    logic [5:0]         entry_index;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         removed_count;
    logic [6:0]         entry_count;
    logic signed [31:0] read_obj_0;
    logic signed [31:0] read_obj_1;
    logic signed [31:0] read_obj_2;
    logic signed [31:0] read_obj_3;
    logic [31:0]        read_tag;
  } rsp_t;

  // Per-cycle control broadcast along the cell chain.
  typedef struct packed {
    logic             shift;
    logic             ins_en;
    logic [PTR_W-1:0] ins_idx;
  } cell_ctl_t;

endpackage

### src/pareto_archive_filter.sv
// Pareto archive filter. The archive is a chain of cells, one entry per cell, and
// every add, check or read request streams the stored entries once through the
// head of the chain: each cycle the head entry is compared with the candidate
// and either dropped or reinserted behind the entries already kept, so order is
// preserved. A request passes from accept through the scan of its stored entries
// to a finish state that posts the result. A clear, an out-of-range read or a
// request on an empty archive skips the scan and goes straight to finish. One
// request is worked on at a time; the result sits in an output register so the
// next request can be taken while it waits, and a result still stalled there
// holds the finish of the next request.
module pareto_archive_filter #(
  parameter int unsigned ARCHIVE_DEPTH  = 64,
  parameter int unsigned MAX_OBJECTIVES = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pafl_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pafl_pkg::rsp_t out_rsp_o,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [2:0]     cfg_data_i
);
  import pafl_pkg::*;

  localparam int unsigned CNT_W = $clog2(ARCHIVE_DEPTH + 1);
  localparam int unsigned CMP_W = CNT_W + 6;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [2:0]       nobj_q;
  logic             max_q;
  logic [CNT_W-1:0] size_q, size_d, r_q, r_d, w_q, w_d, rem_q, rem_d;
  logic             rej_q, rej_d, bad_q, bad_d;
  logic [1:0]       req_q;
  logic [5:0]       idx_q;
  logic [3:0][31:0] cand_q;
  logic [31:0]      ctag_q;
  logic [MAX_OBJECTIVES-1:0][31:0] rd_obj_q;
  logic [31:0]      rd_tag_q;
  logic             out_valid_q;
  rsp_t             out_q, out_d;

  logic [ARCHIVE_DEPTH:0][MAX_OBJECTIVES-1:0][31:0] c_obj;
  logic [ARCHIVE_DEPTH:0][31:0]                     c_tag;
  logic [MAX_OBJECTIVES-1:0][31:0] ins_obj;
  logic [31:0]      ins_tag;
  cell_ctl_t        ctl;
  logic [2:0]       n_eff;
  logic             cb, eb, dom, drop, accept, fin_go, append;
  logic [CNT_W-1:0] ins_pos;
  logic [2:0]       status;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign fin_go     = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // Effective objective count: zero counts as one, excess clips to the maximum.
  always_comb begin
    n_eff = nobj_q;
    if (nobj_q == 3'd0) n_eff = 3'd1;
    if ({29'd0, nobj_q} > MAX_OBJECTIVES) n_eff = 3'(MAX_OBJECTIVES);
  end

  // Dominance test of the candidate against the head cell.
  always_comb begin
    cb = 1'b0;
    eb = 1'b0;
    for (int k = 0; k < MAX_OBJECTIVES; k++) begin
      if (k < int'(n_eff) && cand_q[k] != c_obj[0][k]) begin
        if (max_q ? ($signed(cand_q[k]) > $signed(c_obj[0][k]))
                  : ($signed(cand_q[k]) < $signed(c_obj[0][k]))) begin
          cb = 1'b1;
        end else begin
          eb = 1'b1;
        end
      end
    end
  end

  assign dom    = cb && !eb;
  assign drop   = (req_q != REQ_READ) && !rej_q && dom;
  assign append = (req_q == REQ_ADD) && !rej_q && (w_q < CNT_W'(ARCHIVE_DEPTH));
  // Unscanned entries fill the front, kept ones follow: slot size-1-r+w.
  assign ins_pos = size_q - CNT_W'(1) - r_q + w_q;

  // Chain control and insert data.
  always_comb begin
    ctl = '0;
    ins_obj = c_obj[0];
    ins_tag = c_tag[0];
    if (state_q == S_SCAN) begin
      ctl.shift   = 1'b1;
      ctl.ins_en  = !drop;
      ctl.ins_idx = PTR_W'(ins_pos);
    end else if (fin_go && append) begin
      ctl.ins_en  = 1'b1;
      ctl.ins_idx = PTR_W'(w_q);
      for (int k = 0; k < MAX_OBJECTIVES; k++) ins_obj[k] = cand_q[k];
      ins_tag = ctag_q;
    end
  end

  assign c_obj[ARCHIVE_DEPTH] = '0;
  assign c_tag[ARCHIVE_DEPTH] = '0;

  for (genvar i = 0; i < ARCHIVE_DEPTH; i++) begin : g_cell
    pafl_cell #(.IDX(i), .MAX_OBJ(MAX_OBJECTIVES)) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .nb_obj_i  (c_obj[i+1]),
      .nb_tag_i  (c_tag[i+1]),
      .ins_obj_i (ins_obj),
      .ins_tag_i (ins_tag),
      .obj_o     (c_obj[i]),
      .tag_o     (c_tag[i])
    );
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    size_d  = size_q;
    r_d     = r_q;
    w_d     = w_q;
    rem_d   = rem_q;
    rej_d   = rej_q;
    bad_d   = bad_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          r_d   = '0;
          rem_d = '0;
          rej_d = 1'b0;
          bad_d = (CMP_W'(in_req_i.entry_index) >= CMP_W'(size_q));
          if (in_req_i.req_type != REQ_CLEAR && size_q != '0 &&
              !(in_req_i.req_type == REQ_READ && bad_d)) begin
            state_d = S_SCAN;
            w_d     = '0;
          end else begin
            state_d = S_FIN;
            w_d     = size_q;
          end
        end
      end
      S_SCAN: begin
        r_d = r_q + CNT_W'(1);
        if (drop) begin
          rem_d = rem_q + CNT_W'(1);
        end else begin
          w_d = w_q + CNT_W'(1);
          if (req_q != REQ_READ && !cb) rej_d = 1'b1;
        end
        if (r_d == size_q) state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
          if (req_q == REQ_CLEAR) size_d = '0;
          else if (append) size_d = w_q + CNT_W'(1);
          else size_d = w_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result status.
  always_comb begin
    case (req_q)
      REQ_ADD:   status = rej_q ? ST_REJECTED : (append ? ST_ACCEPTED : ST_FULL);
      REQ_CHECK: status = rej_q ? ST_REJECTED : ST_ACCEPTED;
      REQ_READ:  status = bad_q ? ST_BAD_IDX : ST_DONE;
      default:   status = ST_DONE;
    endcase
  end

  // Result payload; read fields stay zero unless a read hits an entry.
  always_comb begin
    out_d               = '0;
    out_d.status        = status;
    out_d.removed_count = 7'(rem_q);
    out_d.entry_count   = 7'(size_d);
    if (req_q == REQ_READ && !bad_q) begin
      out_d.read_obj_0 = rd_obj_q[0];
      if (MAX_OBJECTIVES > 1) out_d.read_obj_1 = rd_obj_q[1 % MAX_OBJECTIVES];
      if (MAX_OBJECTIVES > 2) out_d.read_obj_2 = rd_obj_q[2 % MAX_OBJECTIVES];
      if (MAX_OBJECTIVES > 3) out_d.read_obj_3 = rd_obj_q[3 % MAX_OBJECTIVES];
      out_d.read_tag = rd_tag_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= '0;
      r_q         <= '0;
      w_q         <= '0;
      rem_q       <= '0;
      rej_q       <= 1'b0;
      bad_q       <= 1'b0;
      nobj_q      <= 3'd2;
      max_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      r_q     <= r_d;
      w_q     <= w_d;
      rem_q   <= rem_d;
      rej_q   <= rej_d;
      bad_q   <= bad_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_NUM_OBJ) nobj_q <= cfg_data_i;
        else if (cfg_index_i == CFG_MAXIMIZE) max_q <= cfg_data_i[0];
      end
      if (fin_go) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Request, read capture and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_req_i.req_type;
      idx_q  <= in_req_i.entry_index;
      cand_q <= {in_req_i.obj_3, in_req_i.obj_2, in_req_i.obj_1, in_req_i.obj_0};
      ctag_q <= in_req_i.solution_tag;
    end
    if (state_q == S_SCAN && CMP_W'(r_q) == CMP_W'(idx_q)) begin
      rd_obj_q <= c_obj[0];
      rd_tag_q <= c_tag[0];
    end
    if (fin_go) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= CNT_W'(ARCHIVE_DEPTH)) else $error("archive size above depth");
  a_kept_le_scanned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> w_q <= r_q) else $error("more kept than scanned");
  a_scan_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> w_q + rem_q == r_q) else $error("scan count mismatch");
  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_q && state_q == S_IDLE) else $error("result not posted");
`endif

endmodule

### src/pafl_cell.sv
module pafl_cell #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned MAX_OBJ = 4
) (
  input  logic                            clk_i,
  input  pafl_pkg::cell_ctl_t             ctl_i,
  input  logic [MAX_OBJ-1:0][31:0]        nb_obj_i,
  input  logic [31:0]                     nb_tag_i,
  input  logic [MAX_OBJ-1:0][31:0]        ins_obj_i,
  input  logic [31:0]                     ins_tag_i,
  output logic [MAX_OBJ-1:0][31:0]        obj_o,
  output logic [31:0]                     tag_o
);
  import pafl_pkg::*;

  logic [MAX_OBJ-1:0][31:0] obj_q;
  logic [31:0]              tag_q;
  logic                     hit;

  assign hit = ctl_i.ins_en && (ctl_i.ins_idx == PTR_W'(IDX));

  // An insert aimed at this cell wins over the shift from the neighbor.
  always_ff @(posedge clk_i) begin
    if (hit) begin
      obj_q <= ins_obj_i;
      tag_q <= ins_tag_i;
    end else if (ctl_i.shift) begin
      obj_q <= nb_obj_i;
      tag_q <= nb_tag_i;
    end
  end

  assign obj_o = obj_q;
  assign tag_o = tag_q;

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pafl_pkg::*;

  localparam int DEPTH = 64;
  localparam int NOBJ = 4;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [2:0] cfg_data_i = '0;

  pareto_archive_filter uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow archive and configuration.
  logic signed [31:0] arc_obj [DEPTH][NOBJ];
  logic [31:0] arc_tag [DEPTH];
  int arc_size;
  logic [2:0] sh_nobj;
  logic sh_max;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;

  // Returns 1 when the candidate dominates the entry, 2 when the entry dominates
  // or equals it, 3 otherwise.
  function automatic int dominance(req_t c, int slot, int n);
    logic signed [31:0] cv [NOBJ];
    bit cb, eb;
    cv = '{c.obj_0, c.obj_1, c.obj_2, c.obj_3};
    cb = 0;
    eb = 0;
    for (int k = 0; k < n; k++) begin
      if (cv[k] != arc_obj[slot][k]) begin
        if (sh_max ? (cv[k] > arc_obj[slot][k]) : (cv[k] < arc_obj[slot][k])) cb = 1;
        else eb = 1;
      end
    end
    if (cb && !eb) return 1;
    if (!cb) return 2;
    return 3;
  endfunction

  function automatic rsp_t archive_response(req_t r);
    rsp_t o;
    int n, w;
    bit rej;
    o = '0;
    n = (sh_nobj < 1) ? 1 : (sh_nobj > NOBJ) ? NOBJ : sh_nobj;
    if (r.req_type == REQ_ADD || r.req_type == REQ_CHECK) begin
      w = 0;
      rej = 0;
      for (int i = 0; i < arc_size; i++) begin
        if (!rej) begin
          int d;
          d = dominance(r, i, n);
          if (d == 1) begin
            o.removed_count++;
            continue;
          end
          if (d == 2) rej = 1;
        end
        arc_obj[w] = arc_obj[i];
        arc_tag[w] = arc_tag[i];
        w++;
      end
      arc_size = w;
      if (rej) o.status = ST_REJECTED;
      else if (r.req_type == REQ_CHECK) o.status = ST_ACCEPTED;
      else if (arc_size >= DEPTH) o.status = ST_FULL;
      else begin
        arc_obj[arc_size] = '{r.obj_0, r.obj_1, r.obj_2, r.obj_3};
        arc_tag[arc_size] = r.solution_tag;
        arc_size++;
        o.status = ST_ACCEPTED;
      end
    end else if (r.req_type == REQ_READ) begin
      if (r.entry_index >= arc_size) o.status = ST_BAD_IDX;
      else begin
        o.status = ST_DONE;
        o.read_obj_0 = arc_obj[r.entry_index][0];
        o.read_obj_1 = arc_obj[r.entry_index][1];
        o.read_obj_2 = arc_obj[r.entry_index][2];
        o.read_obj_3 = arc_obj[r.entry_index][3];
        o.read_tag = arc_tag[r.entry_index];
      end
    end else begin
      arc_size = 0;
      o.status = ST_DONE;
    end
    o.entry_count = 7'(arc_size);
    return o;
  endfunction

  // Driver: presents queued requests and predicts each one on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_rsps.push_back(archive_response(in_req_i));
      void'(pending_reqs.pop_front());
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_req_i <= pending_reqs[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result status=%0d", out_rsp_o.status);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (out_rsp_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_rsp_o.status); errors++;
        end
        if (out_rsp_o.removed_count !== e.removed_count) begin
          $error("removed_count exp %0d got %0d", e.removed_count, out_rsp_o.removed_count);
          errors++;
        end
        if (out_rsp_o.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, out_rsp_o.entry_count);
          errors++;
        end
        if (out_rsp_o.read_obj_0 !== e.read_obj_0) begin
          $error("read_obj_0 exp %0d got %0d", e.read_obj_0, out_rsp_o.read_obj_0); errors++;
        end
        if (out_rsp_o.read_obj_1 !== e.read_obj_1) begin
          $error("read_obj_1 exp %0d got %0d", e.read_obj_1, out_rsp_o.read_obj_1); errors++;
        end
        if (out_rsp_o.read_obj_2 !== e.read_obj_2) begin
          $error("read_obj_2 exp %0d got %0d", e.read_obj_2, out_rsp_o.read_obj_2); errors++;
        end
        if (out_rsp_o.read_obj_3 !== e.read_obj_3) begin
          $error("read_obj_3 exp %0d got %0d", e.read_obj_3, out_rsp_o.read_obj_3); errors++;
        end
        if (out_rsp_o.read_tag !== e.read_tag) begin
          $error("read_tag exp %h got %h", e.read_tag, out_rsp_o.read_tag); errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Picks an objective value: small pools make dominance and ties common.
  function automatic logic [31:0] pick_obj();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($urandom_range(12)) - 32'd6;
    endcase
  endfunction

  function automatic req_t make_req(logic [1:0] kind);
    req_t r;
    r.req_type = kind;
    r.obj_0 = pick_obj();
    r.obj_1 = pick_obj();
    r.obj_2 = pick_obj();
    r.obj_3 = pick_obj();
    r.solution_tag = $urandom;
    r.entry_index = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(arc_size + 2));
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (DEPTH * 2 + 10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [2:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUM_OBJ) sh_nobj = val;
    else sh_max = val[0];
  endtask

  task automatic push_random(int count);
    logic [1:0] kind;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0: kind = REQ_CLEAR;
        1, 2, 3: kind = REQ_READ;
        4, 5, 6: kind = REQ_CHECK;
        default: kind = REQ_ADD;
      endcase
      pending_reqs.push_back(make_req(kind));
    end
  endtask

  initial begin
    req_t r;
    arc_size = 0;
    sh_nobj = 3'd2;
    sh_max = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: read empty, extremes, equal, dominated, check, read, clear.
    send_idle_pct = 13;
    recv_idle_pct = 45;
    r = '0;
    r.req_type = REQ_READ;
    pending_reqs.push_back(r);
    r.req_type = REQ_ADD;
    r.obj_0 = 32'h8000_0000; r.obj_1 = 32'h7fff_ffff;
    r.obj_2 = 32'hffff_ffff; r.obj_3 = 32'h8000_0000; r.solution_tag = 32'hffff_ffff;
    pending_reqs.push_back(r);
    pending_reqs.push_back(r);
    r.obj_0 = 32'h7fff_ffff; r.obj_1 = 32'h8000_0000; r.solution_tag = 32'h0;
    pending_reqs.push_back(r);
    r.obj_0 = 32'h7fff_ffff; r.obj_1 = 32'h7fff_ffff; r.solution_tag = 32'h5a5a_a5a5;
    pending_reqs.push_back(r);
    r.req_type = REQ_CHECK; r.obj_0 = 0; r.obj_1 = 0;
    pending_reqs.push_back(r);
    r.req_type = REQ_READ; r.entry_index = 6'd0;
    pending_reqs.push_back(r);
    r.entry_index = 6'd63;
    pending_reqs.push_back(r);
    r.req_type = REQ_CLEAR;
    pending_reqs.push_back(r);
    wait_drained();

    // Fill to capacity with a front along two objectives, then one more.
    for (int i = 0; i <= DEPTH; i++) begin
      r = '0;
      r.req_type = REQ_ADD;
      r.obj_0 = i; r.obj_1 = -i; r.solution_tag = 32'(i);
      pending_reqs.push_back(r);
    end
    r.req_type = REQ_READ; r.entry_index = 6'd63;
    pending_reqs.push_back(r);
    r.req_type = REQ_CHECK; r.obj_0 = 100; r.obj_1 = 0;
    pending_reqs.push_back(r);
    wait_drained();

    // Random phases over several settings, including the extremes.
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_NUM_OBJ, (ph == 0) ? 3'd0 : (ph == 1) ? 3'd7 : 3'($urandom_range(1, 4)));
      write_cfg(CFG_MAXIMIZE, 1'(ph));
      if (ph < 3) begin
        send_idle_pct = 13; recv_idle_pct = 45;
      end else if (ph < 6) begin
        send_idle_pct = 45; recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      push_random(40);
      while (pending_reqs.size() > 0) @(posedge clk_i);
      wait_drained();
      push_random(40);
      wait_drained();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### filelist.f
src/pafl_pkg.sv
src/pafl_cell.sv
src/pareto_archive_filter.sv
test/tb.sv
